// ----- rtl/core/rpfp_pkg.sv -----
`default_nettype none

package rpfp_pkg;

    // Frame geometry
    localparam int unsigned FRAME_LEN = 23;
    localparam int unsigned HDR_LEN   = 4;
    localparam int unsigned CNT_W     = 5;

    // Offsets with a meaning of their own
    localparam logic [CNT_W-1:0] OFS_STATE = CNT_W'(8);
    localparam logic [CNT_W-1:0] OFS_LAST  = CNT_W'(FRAME_LEN - 1);

    // Header and first header byte
    localparam logic [7:0] HDR_B0 = 8'hf4;
    localparam logic [7:0] HDR_B1 = 8'hf3;
    localparam logic [7:0] HDR_B2 = 8'hf2;
    localparam logic [7:0] HDR_B3 = 8'hf1;

    // Largest legal target state
    localparam logic [7:0] STATE_MAX = 8'h03;

    // One result word
    typedef struct packed {
        logic       moving;
        logic       stationary;
        logic [1:0] target_state;
    } res_t;

    // Expected header byte at a header offset
    function automatic logic [7:0] hdr_byte(input logic [1:0] ofs);
        logic [7:0] val;
        case (ofs)
            2'd0:    val = HDR_B0;
            2'd1:    val = HDR_B1;
            2'd2:    val = HDR_B2;
            default: val = HDR_B3;
        endcase
        return val;
    endfunction

    // Body byte check: fixed bytes, footer and target state range
    function automatic logic body_ok(input logic [CNT_W-1:0] ofs, input logic [7:0] b);
        logic ok;
        case (ofs)
            CNT_W'(4):  ok = (b == 8'h0d);
            CNT_W'(5):  ok = (b == 8'h00);
            CNT_W'(6):  ok = (b == 8'h02);
            CNT_W'(7):  ok = (b == 8'haa);
            OFS_STATE:  ok = (b <= STATE_MAX);
            CNT_W'(17): ok = (b == 8'h55);
            CNT_W'(18): ok = (b == 8'h00);
            CNT_W'(19): ok = (b == 8'hf8);
            CNT_W'(20): ok = (b == 8'hf7);
            CNT_W'(21): ok = (b == 8'hf6);
            CNT_W'(22): ok = (b == 8'hf5);
            default:    ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rpfp_in_reg.sv -----
`default_nettype none

module rpfp_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       adv,
    output logic            step,
    output logic [7:0]      byte_q
);

    logic       vld_reg, vld_next;
    logic [7:0] byte_reg;

    // Hold the word only while the parser cannot take it
    assign rx_stall = vld_reg && !adv;
    assign step     = vld_reg && adv;
    assign byte_q   = byte_reg;

    always_comb
    begin
        vld_next = rx_stall ? vld_reg : rx_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!rx_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rpfp_parse.sv -----
`default_nettype none

module rpfp_parse (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   byte_q,
    output logic              fire,
    output rpfp_pkg::res_t    res
);

    logic [rpfp_pkg::CNT_W-1:0] cnt_reg, cnt_next, cnt_eff;
    logic                       ok_reg, ok_next;
    logic [1:0]                 st_reg, st_next;
    logic                       hdr_phase;

    // Out-of-range count behaves as zero
    assign cnt_eff   = (cnt_reg > rpfp_pkg::OFS_LAST) ? '0 : cnt_reg;
    assign hdr_phase = (cnt_eff < rpfp_pkg::CNT_W'(rpfp_pkg::HDR_LEN));

    // Header hunt, then running check of the body
    always_comb
    begin
        cnt_next = cnt_reg;
        ok_next  = ok_reg;
        st_next  = st_reg;
        fire     = 1'b0;
        if (step)
        begin
            if (hdr_phase)
            begin
                ok_next = 1'b1;
                if (byte_q == rpfp_pkg::hdr_byte(cnt_eff[1:0]))
                begin
                    cnt_next = cnt_eff + 1'b1;
                end
                else if (byte_q == rpfp_pkg::HDR_B0)
                begin
                    cnt_next = rpfp_pkg::CNT_W'(1);
                end
                else
                begin
                    cnt_next = '0;
                end
            end
            else
            begin
                ok_next = ok_reg && rpfp_pkg::body_ok(cnt_eff, byte_q);
                if (cnt_eff == rpfp_pkg::OFS_STATE)
                begin
                    st_next = byte_q[1:0];
                end
                if (cnt_eff == rpfp_pkg::OFS_LAST)
                begin
                    cnt_next = '0;
                    fire     = ok_next;
                end
                else
                begin
                    cnt_next = cnt_eff + 1'b1;
                end
            end
        end
    end

    // Flags from the held target state
    assign res.target_state = st_reg;
    assign res.moving       = st_reg[0];
    assign res.stationary   = st_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ok_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ok_reg  <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/rpfp_out_reg.sv -----
`default_nettype none

module rpfp_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic           fire,
    input  wire rpfp_pkg::res_t res,
    output logic                adv,
    output logic                res_valid,
    input  wire logic           res_stall,
    output rpfp_pkg::res_t      res_q
);

    logic           vld_reg, vld_next;
    rpfp_pkg::res_t res_reg;

    // Register is free when empty or being taken
    assign adv       = !vld_reg || !res_stall;
    assign res_valid = vld_reg;
    assign res_q     = res_reg;

    always_comb
    begin
        vld_next = adv ? (step && fire) : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && step && fire)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/radar_presence_frame_parser_core.sv -----
`default_nettype none

// Frame parser for a presence radar link. Takes one received byte per cycle,
// hunts for the F4 F3 F2 F1 header, collects a 23-byte frame and checks it on
// the fly (fixed bytes, footer F8 F7 F6 F5, target state at most 3). A good
// frame gives one result word with the moving and stationary flags and the
// raw target state; a bad frame gives nothing and hunting restarts. Rate is
// one byte per cycle while no result stall holds the flow; a byte goes
// through an input register and a result register, so a result is valid the
// cycle after the last frame byte is taken. A stalled result register holds
// the input register, which then stalls the receive side.
module radar_presence_frame_parser_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic            moving,
    output logic            stationary,
    output logic [1:0]      target_state
);

    logic           adv;
    logic           step;
    logic [7:0]     byte_q;
    logic           fire;
    rpfp_pkg::res_t res;
    rpfp_pkg::res_t res_q;

    rpfp_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .adv      (adv),
        .step     (step),
        .byte_q   (byte_q)
    );

    rpfp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .byte_q (byte_q),
        .fire   (fire),
        .res    (res)
    );

    rpfp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .fire      (fire),
        .res       (res),
        .adv       (adv),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_q     (res_q)
    );

    assign moving       = res_q.moving;
    assign stationary   = res_q.stationary;
    assign target_state = res_q.target_state;

endmodule

`default_nettype wire
